[hw/rtl/mlpq_pkg.sv]
`timescale 1ns / 1ps
// Shared types and codes for the multi-level priority queue.
// No dependencies; imported by mlpq_ctrl and multi_level_priority_queue_core.
package mlpq_pkg;

	// request kinds carried on s_tuser
	typedef enum logic [1:0] {
		REQ_ENQ  = 2'd0,
		REQ_DEQ  = 2'd1,
		REQ_PEEK = 2'd2,
		REQ_NONE = 2'd3
	} req_t;

	// result status carried on m_tuser
	typedef enum logic [1:0] {
		ST_OK      = 2'd0,
		ST_INVALID = 2'd1,
		ST_EMPTY   = 2'd2,
		ST_FULL    = 2'd3
	} status_t;

	localparam int unsigned VAL_W = 32;
	localparam int unsigned PRIO_W = 4;
	localparam logic [PRIO_W-1:0] LEVELS_RST = 4'd8;

	// result of one request, minus the value read back from the store
	typedef struct packed {
		status_t           status;
		logic [PRIO_W-1:0] level;
		logic              rd;
	} res_t;

endpackage

[hw/rtl/mlpq_ram.sv]
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module mlpq_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 128,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

[hw/rtl/mlpq_ctrl.sv]
`timescale 1ns / 1ps
// Queue control: per-level head/tail/occupancy, priority encoder, store addressing.
// Depends on mlpq_pkg.
module mlpq_ctrl #(
	parameter int PRIO_LEVELS = 8,
	parameter int LEVEL_DEPTH = 16,
	localparam int ADDR_W = ((PRIO_LEVELS * LEVEL_DEPTH) > 1) ?
		$clog2(PRIO_LEVELS * LEVEL_DEPTH) : 1
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                go,
	input  mlpq_pkg::req_t                      req_type,
	input  logic [mlpq_pkg::PRIO_W-1:0]         item_priority,
	input  logic [mlpq_pkg::PRIO_W-1:0]         levels_in_use,
	output mlpq_pkg::res_t                      res,
	output logic                                ram_we,
	output logic [ADDR_W-1:0]                   ram_waddr,
	output logic                                ram_re,
	output logic [ADDR_W-1:0]                   ram_raddr
);
	import mlpq_pkg::*;

	localparam int LVL_W = (PRIO_LEVELS > 1) ? $clog2(PRIO_LEVELS) : 1;
	localparam int PTR_W = $clog2(LEVEL_DEPTH);
	localparam int CNT_W = $clog2(LEVEL_DEPTH + 1);

	logic [PTR_W-1:0] head_q [PRIO_LEVELS];
	logic [PTR_W-1:0] tail_q [PRIO_LEVELS];
	logic [CNT_W-1:0] cnt_q  [PRIO_LEVELS];

	logic [PRIO_W:0]  eff;
	logic             enq_ok;
	logic [LVL_W-1:0] enq_lvl;
	logic             hit;
	logic [LVL_W-1:0] top_lvl;
	logic             we_c;
	logic             re_c;

	// saturate the configured count at the levels built
	assign eff = ({1'b0, levels_in_use} > (PRIO_W+1)'(PRIO_LEVELS)) ?
		(PRIO_W+1)'(PRIO_LEVELS) : {1'b0, levels_in_use};

	assign enq_ok  = (item_priority != '0) && ({1'b0, item_priority} <= eff);
	assign enq_lvl = LVL_W'(item_priority - PRIO_W'(1));

	// highest visible non-empty level wins
	always_comb begin
		hit     = 1'b0;
		top_lvl = '0;
		for (int i = 0; i < PRIO_LEVELS; i++) begin
			if ((cnt_q[i] != '0) && ((PRIO_W+1)'(i) < eff)) begin
				hit     = 1'b1;
				top_lvl = LVL_W'(i);
			end
		end
	end

	always_comb begin
		res.status = ST_OK;
		res.level  = '0;
		res.rd     = 1'b0;
		we_c       = 1'b0;
		re_c       = 1'b0;
		unique case (req_type)
			REQ_ENQ: begin
				if (!enq_ok) begin
					res.status = ST_INVALID;
				end else if (cnt_q[enq_lvl] == CNT_W'(LEVEL_DEPTH)) begin
					res.status = ST_FULL;
				end else begin
					we_c      = 1'b1;
					res.level = item_priority;
				end
			end
			REQ_DEQ, REQ_PEEK: begin
				if (!hit) begin
					res.status = ST_EMPTY;
				end else begin
					re_c      = 1'b1;
					res.rd    = 1'b1;
					res.level = PRIO_W'(32'(top_lvl) + 32'd1);
				end
			end
			default: ;
		endcase
	end

	assign ram_we    = go && we_c;
	assign ram_re    = go && re_c;
	assign ram_waddr = ADDR_W'(enq_lvl) * ADDR_W'(LEVEL_DEPTH) + ADDR_W'(tail_q[enq_lvl]);
	assign ram_raddr = ADDR_W'(top_lvl) * ADDR_W'(LEVEL_DEPTH) + ADDR_W'(head_q[top_lvl]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < PRIO_LEVELS; i++) begin
				head_q[i] <= '0;
				tail_q[i] <= '0;
				cnt_q[i]  <= '0;
			end
		end else begin
			if (ram_we) begin
				tail_q[enq_lvl] <= (tail_q[enq_lvl] == PTR_W'(LEVEL_DEPTH - 1)) ?
					'0 : tail_q[enq_lvl] + PTR_W'(1);
				cnt_q[enq_lvl]  <= cnt_q[enq_lvl] + CNT_W'(1);
			end
			if (ram_re && (req_type == REQ_DEQ)) begin
				head_q[top_lvl] <= (head_q[top_lvl] == PTR_W'(LEVEL_DEPTH - 1)) ?
					'0 : head_q[top_lvl] + PTR_W'(1);
				cnt_q[top_lvl]  <= cnt_q[top_lvl] - CNT_W'(1);
			end
		end
	end

endmodule

[hw/rtl/multi_level_priority_queue_core.sv]
`timescale 1ns / 1ps
// Multi-level priority queue: one FIFO per level in a shared entry RAM.
// Result path: the RAM read and s1 register at accept, then the output register to result valid.
// Throughput: one request per cycle while the result stream is not stalled; the registered RAM read
// and the pointer update in the accept cycle set this, and back-to-back hits on one entry are safe.
// Reset: asynchronous, active low; all levels empty, levels_in_use = 8.
// Entry RAM is not cleared; entries are only read after being written.
// Depends on mlpq_pkg, mlpq_ctrl, mlpq_ram.
module multi_level_priority_queue_core #(
	parameter int PRIO_LEVELS = 8,
	parameter int LEVEL_DEPTH = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	// request stream
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [39:0] s_tdata,   // [31:0] item_value, [35:32] item_priority, rest zero
	input  logic [1:0]  s_tuser,   // [1:0] req_type
	// result stream
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [39:0] m_tdata,   // [31:0] front_value, [35:32] served_level, rest zero
	output logic [1:0]  m_tuser,   // [1:0] status
	// levels_in_use write
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [3:0]  cfg_data
);
	import mlpq_pkg::*;

	localparam int DEPTH  = PRIO_LEVELS * LEVEL_DEPTH;
	localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	logic [PRIO_W-1:0] levels_q;

	logic              go;
	res_t              res;
	logic              ram_we;
	logic              ram_re;
	logic [ADDR_W-1:0] ram_waddr;
	logic [ADDR_W-1:0] ram_raddr;
	logic [VAL_W-1:0]  ram_rdata;

	logic              vld_s1;
	res_t              res_s1;
	logic              adv;

	logic              out_vld_q;
	status_t           out_status_q;
	logic [VAL_W-1:0]  out_front_q;
	logic [PRIO_W-1:0] out_level_q;

	// config register, always writable
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			levels_q <= LEVELS_RST;
		end else if (cfg_valid) begin
			levels_q <= cfg_data;
		end
	end

	// s1 drains into the output register when that is empty or being taken.
	// A stalled s1 blocks new requests, so RAM read data holds (read enable low).
	assign adv      = !out_vld_q || m_tready;
	assign s_tready = !vld_s1 || adv;
	assign go       = s_tvalid && s_tready;

	mlpq_ctrl #(
		.PRIO_LEVELS (PRIO_LEVELS),
		.LEVEL_DEPTH (LEVEL_DEPTH)
	) u_ctrl (
		.clk           (clk),
		.arst_n        (arst_n),
		.go            (go),
		.req_type      (req_t'(s_tuser)),
		.item_priority (s_tdata[35:32]),
		.levels_in_use (levels_q),
		.res           (res),
		.ram_we        (ram_we),
		.ram_waddr     (ram_waddr),
		.ram_re        (ram_re),
		.ram_raddr     (ram_raddr)
	);

	// a write at one edge is visible to a read issued the next cycle
	mlpq_ram #(
		.WIDTH (VAL_W),
		.DEPTH (DEPTH)
	) u_store (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (s_tdata[31:0]),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (s_tready) begin
			vld_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (go) begin
			res_s1 <= res;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (adv) begin
			out_vld_q <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && vld_s1) begin
			out_status_q <= res_s1.status;
			out_level_q  <= res_s1.level;
			out_front_q  <= res_s1.rd ? ram_rdata : '0;
		end
	end

	assign m_tvalid = out_vld_q;
	assign m_tuser  = out_status_q;
	assign m_tdata  = {4'd0, out_level_q, out_front_q};

endmodule
